FILE: design/bwsm_pkg.sv
`timescale 1ns / 1ps

package bwsm_pkg;

   // Store geometry.
   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int DEPTH    = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CALC_W   = 12;

   // Field widths.
   localparam int ELEV_W   = 19;
   localparam int SCALE_W  = 24;
   localparam int FRAC_W   = 8;

   // Window sum and mean.
   localparam int SUM_W    = ELEV_W + ADDR_W + 1;
   localparam int MEAN_W   = SUM_W + FRAC_W;
   localparam int MQ_W     = ELEV_W + FRAC_W + 1;
   localparam int D_W      = MQ_W + 1;

   // Relief powers and moment sums.
   localparam int AD_W     = MQ_W;
   localparam int P2_W     = 2 * AD_W;
   localparam int P3_W     = 3 * AD_W;
   localparam int P4_W     = 4 * AD_W;
   localparam int S2_W     = P2_W + ADDR_W;
   localparam int S3_W     = P3_W + ADDR_W + 2;
   localparam int S4_W     = P4_W + ADDR_W;

   // Scale multiplier, limb by limb.
   localparam int LIMB_W   = 31;
   localparam int NLIMB    = (S4_W + LIMB_W - 1) / LIMB_W;
   localparam int OP_W     = NLIMB * LIMB_W;
   localparam int ACC_W    = OP_W + SCALE_W;
   localparam int MCNT_W   = $clog2(NLIMB + 1);

   // Right shifts that turn scaled sums into whole m^k.
   localparam int SH2      = 16 + 2 * (4 + FRAC_W);
   localparam int SH3      = 16 + 3 * (4 + FRAC_W);
   localparam int SH4      = 16 + 4 * (4 + FRAC_W);
   localparam int Y2_W     = S2_W + SCALE_W - SH2;
   localparam int Y3_W     = S3_W - 1 + SCALE_W - SH3;
   localparam int Y4_W     = S4_W + SCALE_W - SH4;

   // Serial divider.
   localparam int DIV_W    = (Y4_W > MEAN_W) ? Y4_W : MEAN_W;
   localparam int LEN_W    = $clog2(DIV_W + 1);

   // Output widths and limits.
   localparam int C2_W     = 47;
   localparam int C3_W     = 48;
   localparam int C4_W     = 63;
   localparam logic [DIV_W-1:0] C2_MAX  = DIV_W'((65'd1 << 47) - 65'd1);
   localparam logic [DIV_W-1:0] C3_NMAX = DIV_W'(65'd1 << 47);
   localparam logic [DIV_W-1:0] C4_MAX  = DIV_W'((65'd1 << 63) - 65'd1);
   localparam logic [ELEV_W-1:0] RELIEF_MAX = '1;

   // Register reset values.
   localparam logic [6:0]         GRID_W_RST = 7'd64;
   localparam logic [6:0]         GRID_H_RST = 7'd64;
   localparam logic [5:0]         HALF_RST   = 6'd1;
   localparam logic [SCALE_W-1:0] SCALE2_RST = 24'd145636;
   localparam logic [SCALE_W-1:0] SCALE3_RST = 24'd177999;
   localparam logic [SCALE_W-1:0] SCALE4_RST = 24'd207667;

   typedef enum logic [2:0] {
      CSR_GRID_WIDTH   = 3'd0,
      CSR_GRID_HEIGHT  = 3'd1,
      CSR_HALF_WIDTH_X = 3'd2,
      CSR_HALF_WIDTH_Y = 3'd3,
      CSR_SCALE2       = 3'd4,
      CSR_SCALE3       = 3'd5,
      CSR_SCALE4       = 3'd6
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      SEL_MEAN,
      SEL_M2,
      SEL_M3,
      SEL_M4
   } sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_PASS1,
      ST_DRAIN1,
      ST_MDIV,
      ST_MFIX,
      ST_PASS2,
      ST_DRAIN2,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic    accept_wr;
      logic    accept_q;
      logic    setup;
      logic    walk_start;
      logic    walk_en;
      logic    pass2;
      logic    mean_fix;
      logic    mul_start;
      logic    div_start;
      logic    coeff_store;
      logic    out_load;
      sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic err;
      logic walk_last;
      logic pipe_empty;
      logic mul_done;
      logic div_done;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: design/bed_window_smoother_moments_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// req      | req_valid / req_stall  | req_type, req_col, req_row, req_elevation
// rsp      | rsp_valid / rsp_stall  | window_mean, max_local_relief, coeff_*, range_error
// csr      | csr_valid / csr_ready  | csr_index, csr_wdata
//
// A write item is stored as it is taken. A query item makes two walks of its clipped
// window through the single read port of the sample store, then runs the bit-serial
// divider (40, 52, 69 and 84 steps) and the four-step scale multiplier for each
// moment. A range error skips both walks and all of the arithmetic.
// Reset is synchronous and active high; the sample store is not cleared.
// A finished result waits in the output register while the next item is taken.

module bed_window_smoother_moments_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [5:0]                         req_col,
   input  logic [5:0]                         req_row,
   input  logic signed [bwsm_pkg::ELEV_W-1:0] req_elevation,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bwsm_pkg::ELEV_W-1:0] rsp_window_mean,
   output logic [bwsm_pkg::ELEV_W-1:0]        rsp_max_local_relief,
   output logic [bwsm_pkg::C2_W-1:0]          rsp_coeff_second,
   output logic signed [bwsm_pkg::C3_W-1:0]   rsp_coeff_third,
   output logic [bwsm_pkg::C4_W-1:0]          rsp_coeff_fourth,
   output logic                               rsp_range_error,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [bwsm_pkg::SCALE_W-1:0]       csr_wdata
);
   import bwsm_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bwsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   bwsm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_col              (req_col),
      .req_row              (req_row),
      .req_elevation        (req_elevation),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_window_mean      (rsp_window_mean),
      .rsp_max_local_relief (rsp_max_local_relief),
      .rsp_coeff_second     (rsp_coeff_second),
      .rsp_coeff_third      (rsp_coeff_third),
      .rsp_coeff_fourth     (rsp_coeff_fourth),
      .rsp_range_error      (rsp_range_error)
   );

endmodule

FILE: design/bwsm_divider.sv
`timescale 1ns / 1ps

module bwsm_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bwsm_pkg::DIV_W-1:0]  dividend,
   input  logic [bwsm_pkg::CNT_W-1:0]  divisor,
   input  logic [bwsm_pkg::LEN_W-1:0]  len,
   output logic [bwsm_pkg::DIV_W-1:0]  quotient,
   output logic [bwsm_pkg::CNT_W-1:0]  remainder,
   output logic                        done
);
   import bwsm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    trial;
   logic              ge;

   // One quotient bit per cycle, dividend consumed from its top bit.
   always_comb begin
      trial   = {rem_ff, num_ff[DIV_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = len;
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? CNT_W'(trial - {1'b0, dsr_ff}) : CNT_W'(trial);
         cnt_in = cnt_ff - LEN_W'(1);
         if (cnt_ff == LEN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: design/bwsm_datapath.sv
`timescale 1ns / 1ps

module bwsm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [bwsm_pkg::SCALE_W-1:0]       csr_wdata,
   input  logic [5:0]                         req_col,
   input  logic [5:0]                         req_row,
   input  logic signed [bwsm_pkg::ELEV_W-1:0] req_elevation,
   input  bwsm_pkg::dp_cmd_type               cmd,
   output bwsm_pkg::dp_stat_type              stat,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bwsm_pkg::ELEV_W-1:0] rsp_window_mean,
   output logic [bwsm_pkg::ELEV_W-1:0]        rsp_max_local_relief,
   output logic [bwsm_pkg::C2_W-1:0]          rsp_coeff_second,
   output logic signed [bwsm_pkg::C3_W-1:0]   rsp_coeff_third,
   output logic [bwsm_pkg::C4_W-1:0]          rsp_coeff_fourth,
   output logic                               rsp_range_error
);
   import bwsm_pkg::*;

   // Configuration registers.
   logic [6:0]         grid_w_ff, grid_h_ff;
   logic [5:0]         hx_ff, hy_ff;
   logic [SCALE_W-1:0] scale2_ff, scale3_ff, scale4_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= GRID_W_RST;
         grid_h_ff <= GRID_H_RST;
         hx_ff     <= HALF_RST;
         hy_ff     <= HALF_RST;
         scale2_ff <= SCALE2_RST;
         scale3_ff <= SCALE3_RST;
         scale4_ff <= SCALE4_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:   grid_w_ff <= csr_wdata[6:0];
            CSR_GRID_HEIGHT:  grid_h_ff <= csr_wdata[6:0];
            CSR_HALF_WIDTH_X: hx_ff     <= csr_wdata[5:0];
            CSR_HALF_WIDTH_Y: hy_ff     <= csr_wdata[5:0];
            CSR_SCALE2:       scale2_ff <= csr_wdata;
            CSR_SCALE3:       scale3_ff <= csr_wdata;
            CSR_SCALE4:       scale4_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sample store: one write port, one registered read port.
   logic signed [ELEV_W-1:0] mem [DEPTH];
   logic signed [ELEV_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic [COL_W-1:0]         cw_ff;
   logic [ROW_W-1:0]         rw_ff;

   assign wr_addr = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(MAX_COLS)) + ADDR_W'(req_col);
   assign rd_addr = ADDR_W'(ADDR_W'(rw_ff) * ADDR_W'(MAX_COLS)) + ADDR_W'(cw_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept_wr && (32'(req_col) < MAX_COLS) && (32'(req_row) < MAX_ROWS)) begin
         mem[wr_addr] <= req_elevation;
      end
      if (cmd.walk_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Query point and window bounds, clipped to the grid in use.
   logic [5:0]        qcol_ff, qrow_ff;
   logic [CALC_W-1:0] gw, gh, qc, qr, hx, hy;
   logic [CALC_W-1:0] c0, c1, r0, r1;
   logic              err_in, err_ff;
   logic [COL_W-1:0]  c0_ff, c1_ff;
   logic [ROW_W-1:0]  r0_ff, r1_ff;

   always_comb begin
      gw = CALC_W'(grid_w_ff);
      gh = CALC_W'(grid_h_ff);
      if (gw == '0) begin
         gw = CALC_W'(1);
      end else if (gw > CALC_W'(MAX_COLS)) begin
         gw = CALC_W'(MAX_COLS);
      end
      if (gh == '0) begin
         gh = CALC_W'(1);
      end else if (gh > CALC_W'(MAX_ROWS)) begin
         gh = CALC_W'(MAX_ROWS);
      end
      qc = CALC_W'(qcol_ff);
      qr = CALC_W'(qrow_ff);
      hx = CALC_W'(hx_ff);
      hy = CALC_W'(hy_ff);
      err_in = (hx >= gw) || (hy >= gh) || (qc >= gw) || (qr >= gh);
      c0 = (qc > hx) ? qc - hx : '0;
      c1 = (qc + hx < gw) ? qc + hx : gw - CALC_W'(1);
      r0 = (qr > hy) ? qr - hy : '0;
      r1 = (qr + hy < gh) ? qr + hy : gh - CALC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_q) begin
         qcol_ff <= req_col;
         qrow_ff <= req_row;
      end
      if (cmd.setup) begin
         err_ff <= err_in;
         c0_ff  <= COL_W'(c0);
         c1_ff  <= COL_W'(c1);
         r0_ff  <= ROW_W'(r0);
         r1_ff  <= ROW_W'(r1);
      end
   end

   // Window walker, row by row.
   logic walk_last;
   assign walk_last = (cw_ff == c1_ff) && (rw_ff == r1_ff);

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         cw_ff <= c0_ff;
         rw_ff <= r0_ff;
      end else if (cmd.walk_en) begin
         if (cw_ff == c1_ff) begin
            cw_ff <= c0_ff;
            rw_ff <= rw_ff + ROW_W'(1);
         end else begin
            cw_ff <= cw_ff + COL_W'(1);
         end
      end
   end

   // Valid flags of the read and relief pipeline.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.walk_en;
         v2_ff <= v1_ff && cmd.pass2;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   // First pass: window sum and sample count.
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (v1_ff && !cmd.pass2) begin
         sum_ff <= sum_ff + SUM_W'(rdata_ff);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Shared divider.
   logic [DIV_W-1:0] div_dividend, quo;
   logic [LEN_W-1:0] div_len;
   logic [CNT_W-1:0] rem;
   logic             div_done;
   logic [SUM_W-1:0] sum_mag;
   logic [ACC_W-1:0] acc_ff;

   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      unique case (cmd.sel)
         SEL_MEAN: begin
            div_dividend = DIV_W'({sum_mag, FRAC_W'(0)}) << (DIV_W - MEAN_W);
            div_len      = LEN_W'(MEAN_W);
         end
         SEL_M2: begin
            div_dividend = DIV_W'(acc_ff >> SH2) << (DIV_W - Y2_W);
            div_len      = LEN_W'(Y2_W);
         end
         SEL_M3: begin
            div_dividend = DIV_W'(acc_ff >> SH3) << (DIV_W - Y3_W);
            div_len      = LEN_W'(Y3_W);
         end
         SEL_M4: begin
            div_dividend = DIV_W'(acc_ff >> SH4) << (DIV_W - Y4_W);
            div_len      = LEN_W'(Y4_W);
         end
         default: begin
            div_dividend = '0;
            div_len      = LEN_W'(1);
         end
      endcase
   end

   bwsm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (cnt_ff),
      .len       (div_len),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   // Mean in 1/(16*2^FRAC_W) m, rounded toward minus infinity.
   logic signed [MQ_W-1:0] mq_ff;
   logic [MQ_W-1:0]        q_up;

   assign q_up = MQ_W'(quo) + MQ_W'(rem != '0);

   always_ff @(posedge clock) begin
      if (cmd.mean_fix) begin
         mq_ff <= sum_ff[SUM_W-1] ? -$signed(q_up) : $signed(MQ_W'(quo));
      end
   end

   // Second pass: relief and its powers, one sample per cycle.
   logic signed [D_W-1:0]   d_in, d2_ff, maxd_ff;
   logic [AD_W-1:0]         ad3_ff, ad4_ff, ad5_ff, ad6_ff;
   logic                    neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [P2_W-1:0]         p2_ff, pa_ff, pb_ff;
   logic [P3_W-1:0]         p3_ff;
   logic [P2_W-1:0]         qa_ff, qb_ff, qc_ff;
   logic [P4_W-1:0]         p4_ff;
   logic [S2_W-1:0]         s2_ff;
   logic signed [S3_W-1:0]  s3_ff, s3_term;
   logic [S4_W-1:0]         s4_ff;

   assign d_in = $signed({{(D_W - ELEV_W - FRAC_W){rdata_ff[ELEV_W-1]}}, rdata_ff,
                          FRAC_W'(0)})
                 - $signed({{(D_W - MQ_W){mq_ff[MQ_W-1]}}, mq_ff});
   assign s3_term = neg6_ff ? -$signed(S3_W'(p3_ff)) : $signed(S3_W'(p3_ff));

   always_ff @(posedge clock) begin
      d2_ff   <= d_in;
      ad3_ff  <= d2_ff[D_W-1] ? AD_W'(-d2_ff) : AD_W'(d2_ff);
      neg3_ff <= d2_ff[D_W-1];
      p2_ff   <= ad3_ff * ad3_ff;
      ad4_ff  <= ad3_ff;
      neg4_ff <= neg3_ff;
      pa_ff   <= p2_ff[AD_W-1:0] * ad4_ff;
      pb_ff   <= p2_ff[P2_W-1:AD_W] * ad4_ff;
      ad5_ff  <= ad4_ff;
      neg5_ff <= neg4_ff;
      p3_ff   <= P3_W'(pa_ff) + (P3_W'(pb_ff) << AD_W);
      ad6_ff  <= ad5_ff;
      neg6_ff <= neg5_ff;
      qa_ff   <= p3_ff[AD_W-1:0] * ad6_ff;
      qb_ff   <= p3_ff[2*AD_W-1:AD_W] * ad6_ff;
      qc_ff   <= p3_ff[P3_W-1:2*AD_W] * ad6_ff;
      p4_ff   <= P4_W'(qa_ff) + (P4_W'(qb_ff) << AD_W) + (P4_W'(qc_ff) << (2 * AD_W));
   end

   // Moment sums and largest relief.
   always_ff @(posedge clock) begin
      if (cmd.mean_fix) begin
         maxd_ff <= '0;
         s2_ff   <= '0;
         s3_ff   <= '0;
         s4_ff   <= '0;
      end else begin
         if (v2_ff && (d2_ff > maxd_ff)) begin
            maxd_ff <= d2_ff;
         end
         if (v4_ff) begin
            s2_ff <= s2_ff + S2_W'(p2_ff);
         end
         if (v6_ff) begin
            s3_ff <= s3_ff + s3_term;
         end
         if (v8_ff) begin
            s4_ff <= s4_ff + S4_W'(p4_ff);
         end
      end
   end

   // Scale multiplier: one limb of the sum per cycle, top limb first.
   logic [OP_W-1:0]           op_ff;
   logic [SCALE_W-1:0]        msc_ff;
   logic [MCNT_W-1:0]         mcnt_ff;
   logic                      mbusy_ff, mdone_ff;
   logic [LIMB_W+SCALE_W-1:0] limb_prod;
   logic [OP_W-1:0]           op_sel;
   logic [SCALE_W-1:0]        sc_sel;

   assign limb_prod = op_ff[OP_W-1 -: LIMB_W] * msc_ff;

   always_comb begin
      unique case (cmd.sel)
         SEL_M2: begin
            op_sel = OP_W'(s2_ff);
            sc_sel = scale2_ff;
         end
         SEL_M3: begin
            op_sel = s3_ff[S3_W-1] ? OP_W'(-s3_ff) : OP_W'(s3_ff);
            sc_sel = scale3_ff;
         end
         SEL_M4: begin
            op_sel = OP_W'(s4_ff);
            sc_sel = scale4_ff;
         end
         default: begin
            op_sel = '0;
            sc_sel = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
      end else begin
         mdone_ff <= mbusy_ff && (mcnt_ff == MCNT_W'(1));
         if (cmd.mul_start) begin
            mbusy_ff <= 1'b1;
         end else if (mbusy_ff && (mcnt_ff == MCNT_W'(1))) begin
            mbusy_ff <= 1'b0;
         end
      end
      if (cmd.mul_start) begin
         op_ff   <= op_sel;
         msc_ff  <= sc_sel;
         mcnt_ff <= MCNT_W'(NLIMB);
         acc_ff  <= '0;
      end else if (mbusy_ff) begin
         op_ff   <= op_ff << LIMB_W;
         mcnt_ff <= mcnt_ff - MCNT_W'(1);
         acc_ff  <= (acc_ff << LIMB_W) + ACC_W'(limb_prod);
      end
   end

   // Coefficients, truncated and saturated.
   logic [C2_W-1:0]         c2_ff;
   logic signed [C3_W-1:0]  c3_ff;
   logic [C4_W-1:0]         c4_ff;
   logic [DIV_W-1:0]        mag3;

   assign mag3 = (quo > C3_NMAX) ? C3_NMAX : quo;

   always_ff @(posedge clock) begin
      if (cmd.coeff_store) begin
         unique case (cmd.sel)
            SEL_M2: c2_ff <= (quo > C2_MAX) ? C2_W'(C2_MAX) : C2_W'(quo);
            SEL_M3: begin
               if (!s3_ff[S3_W-1]) begin
                  c3_ff <= (quo > C2_MAX) ? $signed(C3_W'(C2_MAX)) : $signed(C3_W'(quo));
               end else begin
                  c3_ff <= -$signed(C3_W'(mag3));
               end
            end
            SEL_M4: c4_ff <= (quo > C4_MAX) ? C4_W'(C4_MAX) : C4_W'(quo);
            default: begin
            end
         endcase
      end
   end

   // Result register: holds one item while the next query runs.
   logic                      rv_ff;
   logic signed [ELEV_W-1:0]  o_bed_ff;
   logic [ELEV_W-1:0]         o_rel_ff;
   logic [C2_W-1:0]           o_c2_ff;
   logic signed [C3_W-1:0]    o_c3_ff;
   logic [C4_W-1:0]           o_c4_ff;
   logic                      o_err_ff;
   logic [D_W-FRAC_W-1:0]     relief;

   assign relief = maxd_ff[D_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rv_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rv_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         o_err_ff <= err_ff;
         if (err_ff) begin
            o_bed_ff <= '0;
            o_rel_ff <= '0;
            o_c2_ff  <= '0;
            o_c3_ff  <= '0;
            o_c4_ff  <= '0;
         end else begin
            o_bed_ff <= $signed(ELEV_W'(mq_ff >>> FRAC_W));
            o_rel_ff <= (relief > (D_W-FRAC_W)'(RELIEF_MAX)) ? RELIEF_MAX : ELEV_W'(relief);
            o_c2_ff  <= c2_ff;
            o_c3_ff  <= c3_ff;
            o_c4_ff  <= c4_ff;
         end
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_window_mean      = o_bed_ff;
   assign rsp_max_local_relief = o_rel_ff;
   assign rsp_coeff_second     = o_c2_ff;
   assign rsp_coeff_third      = o_c3_ff;
   assign rsp_coeff_fourth     = o_c4_ff;
   assign rsp_range_error      = o_err_ff;

   // Status to the controller.
   always_comb begin
      stat.err        = err_ff;
      stat.walk_last  = walk_last;
      stat.pipe_empty = !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || v6_ff || v7_ff
                          || v8_ff);
      stat.mul_done   = mdone_ff;
      stat.div_done   = div_done;
      stat.out_free   = !rv_ff || !rsp_stall;
   end

endmodule

FILE: design/bwsm_ctrl.sv
`timescale 1ns / 1ps

module bwsm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_type,
   output logic                  req_stall,
   output bwsm_pkg::dp_cmd_type  cmd,
   input  bwsm_pkg::dp_stat_type stat
);
   import bwsm_pkg::*;

   ctrl_state_type state_ff, state_in;
   sel_type        sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_MEAN;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // Sequencing of a query: sum pass, mean divide, moment pass, three scalings, each with its divide.
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_type == REQ_WRITE) begin
                  cmd.accept_wr = 1'b1;
               end else begin
                  cmd.accept_q = 1'b1;
                  state_in     = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            sel_in = SEL_MEAN;
            if (stat.err) begin
               state_in = ST_DONE;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = ST_PASS1;
            end
         end
         ST_PASS1: begin
            cmd.walk_en = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            if (stat.pipe_empty) begin
               cmd.div_start = 1'b1;
               state_in      = ST_MDIV;
            end
         end
         ST_MDIV: begin
            if (stat.div_done) begin
               state_in = ST_MFIX;
            end
         end
         ST_MFIX: begin
            cmd.mean_fix   = 1'b1;
            cmd.walk_start = 1'b1;
            sel_in         = SEL_M2;
            state_in       = ST_PASS2;
         end
         ST_PASS2: begin
            cmd.pass2   = 1'b1;
            cmd.walk_en = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_DRAIN2;
            end
         end
         ST_DRAIN2: begin
            cmd.pass2 = 1'b1;
            if (stat.pipe_empty) begin
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (stat.mul_done) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.coeff_store = 1'b1;
               unique case (sel_ff)
                  SEL_M2: begin
                     sel_in   = SEL_M3;
                     state_in = ST_MUL_GO;
                  end
                  SEL_M3: begin
                     sel_in   = SEL_M4;
                     state_in = ST_MUL_GO;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: verif/tb_bed_window_smoother_moments_top.sv
`timescale 1ns / 1ps

module tb_bed_window_smoother_moments_top;
   import bwsm_pkg::*;

   localparam int STALL_LIMIT = 200000;

   typedef struct {
      req_kind_type      kind;
      logic [5:0]        col;
      logic [5:0]        row;
      logic signed [18:0] elev;
   } bed_item_type;

   typedef struct {
      logic signed [18:0] bed;
      logic [18:0]        relief;
      logic [46:0]        c2;
      logic signed [47:0] c3;
      logic [62:0]        c4;
      logic               err;
   } moments_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_type = 1'b0;
   logic [5:0]                 req_col = '0;
   logic [5:0]                 req_row = '0;
   logic signed [ELEV_W-1:0]   req_elevation = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [ELEV_W-1:0]   rsp_window_mean;
   logic [ELEV_W-1:0]          rsp_max_local_relief;
   logic [C2_W-1:0]            rsp_coeff_second;
   logic signed [C3_W-1:0]     rsp_coeff_third;
   logic [C4_W-1:0]            rsp_coeff_fourth;
   logic                       rsp_range_error;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [2:0]                 csr_index = '0;
   logic [SCALE_W-1:0]         csr_wdata = '0;

   bed_window_smoother_moments_top dut (.*);

   // Shadow copy of the sample store and the registers.
   logic signed [18:0] bed_store [4096];
   logic [6:0]  shadow_gw = 7'd64, shadow_gh = 7'd64;
   logic [5:0]  shadow_hx = 6'd1, shadow_hy = 6'd1;
   logic [23:0] shadow_s2 = 24'd145636, shadow_s3 = 24'd177999, shadow_s4 = 24'd207667;

   bed_item_type pending_items[$];
   moments_type  expected_moments[$];
   logic      req_taken = 1'b0;
   logic      hold = 1'b0;
   int        send_idle = 28, recv_idle = 58;
   int        fail_count = 0, quiet_cycles = 0;
   int        queries_seen = 0, errors_seen = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   // Mean, peak relief and scaled moments of the clipped window around a point.
   function automatic moments_type predict_window(logic [5:0] col, logic [5:0] row);
      moments_type r;
      int gw, gh, c0, c1, r0, r1, cnt, ci, ri;
      longint sum, mq, d, maxd;
      longint unsigned ad;
      logic [199:0] s2, s4, p, mag;
      logic signed [199:0] s3;
      r = '{default: '0};
      gw = shadow_gw < 1 ? 1 : (shadow_gw > 64 ? 64 : int'(shadow_gw));
      gh = shadow_gh < 1 ? 1 : (shadow_gh > 64 ? 64 : int'(shadow_gh));
      ci = col;
      ri = row;
      if (shadow_hx >= gw || shadow_hy >= gh || ci >= gw || ri >= gh) begin
         r.err = 1'b1;
         return r;
      end
      c0 = ci > shadow_hx ? ci - shadow_hx : 0;
      c1 = ci + shadow_hx < gw ? ci + shadow_hx : gw - 1;
      r0 = ri > shadow_hy ? ri - shadow_hy : 0;
      r1 = ri + shadow_hy < gh ? ri + shadow_hy : gh - 1;
      sum = 0;
      cnt = 0;
      for (int y = r0; y <= r1; y++)
         for (int x = c0; x <= c1; x++) begin
            sum += longint'(bed_store[y * 64 + x]);
            cnt++;
         end
      mq = floor_div(sum * 256, cnt);
      s2 = '0; s3 = '0; s4 = '0; maxd = 0;
      for (int y = r0; y <= r1; y++)
         for (int x = c0; x <= c1; x++) begin
            d = longint'(bed_store[y * 64 + x]) * 256 - mq;
            ad = d < 0 ? -d : d;
            if (d > maxd) maxd = d;
            p = 200'(ad) * 200'(ad);
            s2 += p;
            p = p * 200'(ad);
            if (d < 0) s3 -= $signed(p);
            else s3 += $signed(p);
            p = p * 200'(ad);
            s4 += p;
         end
      r.bed = 19'(mq >>> 8);
      r.relief = (maxd >> 8) > 64'h7FFFF ? 19'h7FFFF : 19'(maxd >> 8);
      p = (s2 * 200'(shadow_s2) / 200'(cnt)) >> 40;
      r.c2 = p > 200'((65'd1 << 47) - 1) ? '1 : p[46:0];
      mag = s3 < 0 ? 200'(-s3) : 200'(s3);
      p = (mag * 200'(shadow_s3) / 200'(cnt)) >> 52;
      if (s3 >= 0) r.c3 = p > 200'((65'd1 << 47) - 1) ? 48'sh7FFF_FFFF_FFFF : 48'(p);
      else r.c3 = -(p > 200'(65'd1 << 47) ? 48'sh8000_0000_0000 : 48'(p));
      p = (s4 * 200'(shadow_s4) / 200'(cnt)) >> 64;
      r.c4 = p > 200'((65'd1 << 63) - 1) ? '1 : p[62:0];
      return r;
   endfunction

   // Driver: presents the next pending item at the falling edge.
   always @(negedge clock) begin
      logic v;
      bed_item_type it;
      v = req_valid;
      if (reset) begin
         v = 1'b0;
      end else begin
         if (req_valid && req_taken) v = 1'b0;
         if (!v && !hold && pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
            it = pending_items.pop_front();
            v = 1'b1;
            req_type <= it.kind;
            req_col <= it.col;
            req_row <= it.row;
            req_elevation <= it.elev;
         end
      end
      req_valid <= v;
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_idle);
   end

   // Monitor: tracks accepted items, predicts and checks results.
   always @(posedge clock) begin
      moments_type e;
      bit busy;
      busy = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            busy = 1'b1;
            if (req_type == REQ_WRITE) bed_store[{req_row, req_col}] = req_elevation;
            else expected_moments.push_back(predict_window(req_col, req_row));
         end
         if (csr_valid && csr_ready) busy = 1'b1;
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            if (expected_moments.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               e = expected_moments.pop_front();
               queries_seen++;
               if (e.err) errors_seen++;
               if (rsp_window_mean !== e.bed) begin
                  $error("window_mean expected %0d got %0d", e.bed, rsp_window_mean);
                  fail_count++;
               end
               if (rsp_max_local_relief !== e.relief) begin
                  $error("max_local_relief expected %0d got %0d", e.relief,
                         rsp_max_local_relief);
                  fail_count++;
               end
               if (rsp_coeff_second !== e.c2) begin
                  $error("coeff_second expected %0d got %0d", e.c2, rsp_coeff_second);
                  fail_count++;
               end
               if (rsp_coeff_third !== e.c3) begin
                  $error("coeff_third expected %0d got %0d", e.c3, rsp_coeff_third);
                  fail_count++;
               end
               if (rsp_coeff_fourth !== e.c4) begin
                  $error("coeff_fourth expected %0d got %0d", e.c4, rsp_coeff_fourth);
                  fail_count++;
               end
               if (rsp_range_error !== e.err) begin
                  $error("range_error expected %0d got %0d", e.err, rsp_range_error);
                  fail_count++;
               end
            end
         end
      end
      // Watchdog on cycles without any handshake.
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [23:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GRID_WIDTH:   shadow_gw = val[6:0];
         CSR_GRID_HEIGHT:  shadow_gh = val[6:0];
         CSR_HALF_WIDTH_X: shadow_hx = val[5:0];
         CSR_HALF_WIDTH_Y: shadow_hy = val[5:0];
         CSR_SCALE2:       shadow_s2 = val;
         CSR_SCALE3:       shadow_s3 = val;
         default:          shadow_s4 = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(int gw, int gh, int hx, int hy, int s2, int s3, int s4);
      write_reg(CSR_GRID_WIDTH, 24'(gw));
      write_reg(CSR_GRID_HEIGHT, 24'(gh));
      write_reg(CSR_HALF_WIDTH_X, 24'(hx));
      write_reg(CSR_HALF_WIDTH_Y, 24'(hy));
      write_reg(CSR_SCALE2, 24'(s2));
      write_reg(CSR_SCALE3, 24'(s3));
      write_reg(CSR_SCALE4, 24'(s4));
   endtask

   // Waits until every item is taken and answered, then lets a write settle.
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_moments.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_item(req_kind_type kind, int col, int row, int elev);
      bed_item_type it;
      it.kind = kind;
      it.col = 6'(col);
      it.row = 6'(row);
      it.elev = 19'(elev);
      pending_items.push_back(it);
   endtask

   function automatic int rand_elev();
      case ($urandom_range(7))
         0:       return $urandom_range(1) ? 262143 : -262144;
         1, 2, 3: return int'($signed(19'($urandom)));
         default: return int'($urandom_range(4000)) - 2000;
      endcase
   endfunction

   // Random mix of writes and queries, mostly inside the grid in use.
   task automatic push_random(int n);
      int gw, gh;
      gw = shadow_gw < 1 ? 1 : (shadow_gw > 64 ? 64 : int'(shadow_gw));
      gh = shadow_gh < 1 ? 1 : (shadow_gh > 64 ? 64 : int'(shadow_gh));
      repeat (n) begin
         if ($urandom_range(9) < 4)
            push_item(REQ_WRITE, $urandom_range(63), $urandom_range(63), rand_elev());
         else if ($urandom_range(9) == 0)
            push_item(REQ_QUERY, $urandom_range(63), $urandom_range(63), rand_elev());
         else
            push_item(REQ_QUERY, $urandom_range(gw - 1), $urandom_range(gh - 1), rand_elev());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the 8 x 8 corner and all of column 0, so that no query reads an unwritten
      // entry: every grid used below stays inside that area or answers with a range error.
      for (int a = 0; a < 64; a++) push_item(REQ_WRITE, a % 8, a / 8, rand_elev());
      for (int y = 8; y < 64; y++) push_item(REQ_WRITE, 0, y, rand_elev());
      drain();

      // Directed items at the default window size.
      set_window(8, 8, 1, 1, 145636, 177999, 207667);
      for (int k = 0; k < 9; k++) push_item(REQ_WRITE, 1 + k % 3, 1 + k / 3, 262143);
      push_item(REQ_QUERY, 2, 2, 0);
      for (int k = 0; k < 9; k++) push_item(REQ_WRITE, 5 + k % 3, 5 + k / 3, -262144);
      push_item(REQ_QUERY, 6, 6, 0);
      push_item(REQ_QUERY, 0, 0, 0);
      push_item(REQ_QUERY, 7, 0, 0);
      push_item(REQ_QUERY, 0, 7, 0);
      push_item(REQ_QUERY, 7, 7, 0);
      drain();
      push_random(30);
      drain();

      // Smallest grid with the largest scales.
      set_window(1, 1, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      push_item(REQ_QUERY, 0, 0, 0);
      push_item(REQ_QUERY, 1, 0, 0);
      push_random(20);
      drain();

      send_idle = 58;
      recv_idle = 28;
      set_window(8, 6, 3, 2, $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                 $urandom_range(24'hFFFFFF));
      push_random(40);
      // Sender holds off until every query has been answered.
      while (pending_items.size() > 20) @(posedge clock);
      hold = 1'b1;
      while (req_valid || expected_moments.size() > 0) @(posedge clock);
      hold = 1'b0;
      drain();

      // Grid sizes outside the legal range, zero scales.
      set_window(0, 127, 0, 63, 0, 0, 0);
      push_random(30);
      drain();

      // Full-row windows, and whole-grid windows.
      set_window(8, 8, 7, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      push_random(25);
      drain();
      set_window(8, 8, 7, 7, 145636, 177999, 207667);
      push_item(REQ_QUERY, 4, 4, 0);
      push_item(REQ_QUERY, 0, 7, 0);
      drain();

      send_idle = 0;
      recv_idle = 0;
      set_window(8, 8, 5, 4, $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                 $urandom_range(24'hFFFFFF));
      push_random(40);
      drain();

      // Half-width not below the grid size.
      set_window(5, 64, 5, 2, 145636, 177999, 207667);
      push_random(20);
      drain();
      set_window(8, 8, 2, 1, $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                 $urandom_range(24'hFFFFFF));
      push_random(30);
      drain();

      $display("Covered %0d query results (%0d range errors) across nine window settings",
               queries_seen, errors_seen);
      $display("with clipped edges, clamped grid sizes, saturated moments and idle mixes.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
